FILE: rtl/tdpf_pkg.sv
package tdpf_pkg;

	localparam int NUM_W    = 64;
	localparam int FACTOR_W = 21;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 21;
	localparam int TDATA_W  = 88;
	localparam int SLOTS    = 64;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int STEP_W   = 6;

	localparam logic [CFG_W-1:0] LIMIT_RESET = 21'd1048576;

	typedef enum logic [STATUS_W-1:0] {
		STAT_FACTOR = 2'd0,
		STAT_ONE    = 2'd1,
		STAT_ZERO   = 2'd2,
		STAT_COF    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LAUNCH,
		S_DIV,
		S_FINAL,
		S_COF,
		S_RD,
		S_OUT,
		S_SPECIAL
	} state_t;

	typedef struct packed {
		logic             done;
		logic             rem_zero;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

FILE: rtl/tdpf_div.sv
module tdpf_div #(
	parameter int DW = 21
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tdpf_pkg::NUM_W-1:0] dividend,
	input  logic [DW-1:0]              divisor,
	output tdpf_pkg::div_rsp_t         rsp
);
	import tdpf_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DW-1:0]     acc_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DW-1:0]     dvs_q;

	logic [DW:0]   trial;
	logic          ge;
	logic [DW-1:0] acc_d;

	// restoring division, one quotient bit a cycle; dividend shifts out as quotient shifts in
	always_comb begin
		trial = {acc_q, quo_q[NUM_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		acc_d = ge ? DW'(trial - {1'b0, dvs_q}) : DW'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (&step_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= acc_d;
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.rem_zero = (acc_q == '0);
	assign rsp.quot     = quo_q;

endmodule

FILE: rtl/tdpf_store.sv
module tdpf_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 21
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/trial_division_prime_factorizer_unit.sv
// Trial-division factorizer. Each 64-bit word on s_t* is split into prime factors by dividing
// out 2, 3, 4, ... up to the configured divisor limit (clamped to 2..MAX_DIVISOR) or until
// d*d exceeds the remainder. Results leave on m_t* largest first, one word per factor, the
// final word carrying tlast; a remainder left above the limit leads as a status-3 cofactor.
// Inputs 0 and 1 give a single status word. One bit-serial divider does all the work, one
// division per trial divisor and per factor removed, so an item's time grows with the count
// of trial divisors plus factors; each factor word out passes through a read state and an
// output state. s_tready is low for the whole of an item.
module trial_division_prime_factorizer_unit #(
	parameter int MAX_DIVISOR = 1048576
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [tdpf_pkg::NUM_W-1:0]   s_tdata,  // [63:0] number
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [tdpf_pkg::TDATA_W-1:0] m_tdata,  // [20:0] factor, [84:21] cofactor, zero pad
	output logic [tdpf_pkg::STATUS_W-1:0] m_tuser, // [1:0] status
	output logic                         m_tlast,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tdpf_pkg::CFG_W-1:0]   cfg_data  // divisor_limit
);
	import tdpf_pkg::*;

	localparam int LW = $clog2(MAX_DIVISOR + 1);

	state_t               state_q, state_d;
	logic [CFG_W-1:0]     cfg_q;
	logic [LW-1:0]        lim_q;
	logic [LW-1:0]        dvs_q;
	logic [NUM_W-1:0]     rem_q;
	logic [NUM_W-1:0]     cof_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     idx_q;
	status_t              status_q;

	div_rsp_t             rsp;
	logic                 div_start;
	logic                 mem_we;
	logic [LW-1:0]        mem_wdata;
	logic [LW-1:0]        rd_data;

	logic                 in_acc, out_acc;
	logic [31:0]          cfg_ext;
	logic [LW-1:0]        lim_next;
	logic                 d_past_root, d_at_lim, rem_gt1, rem_le_lim, left_store;
	logic [CNT_W-1:0]     cnt_fin;
	logic [FACTOR_W-1:0]  factor;
	logic [NUM_W-1:0]     cofactor;

	assign in_acc    = s_tvalid && s_tready;
	assign out_acc   = m_tvalid && m_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		cfg_ext = 32'(cfg_q);
		if (cfg_ext < 32'd2) begin
			lim_next = LW'(2);
		end else if (cfg_ext > 32'(MAX_DIVISOR)) begin
			lim_next = LW'(MAX_DIVISOR);
		end else begin
			lim_next = LW'(cfg_ext);
		end
	end

	// d > rem/d is the same test as d*d > rem
	assign d_past_root = NUM_W'(dvs_q) > rsp.quot;
	assign d_at_lim    = dvs_q >= lim_q;
	assign rem_gt1     = rem_q > NUM_W'(1);
	assign rem_le_lim  = rem_q <= NUM_W'(lim_q);
	assign left_store  = rem_gt1 && rem_le_lim;
	assign cnt_fin     = cnt_q + CNT_W'(left_store && !cnt_q[CNT_W-1]);

	tdpf_div #(.DW(LW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rem_q),
		.divisor  (dvs_q),
		.rsp      (rsp)
	);

	tdpf_store #(.DEPTH(SLOTS), .WIDTH(LW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (mem_wdata),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (s_tdata == NUM_W'(0) || s_tdata == NUM_W'(1)) begin
						state_d = S_SPECIAL;
					end else begin
						state_d = S_LAUNCH;
					end
				end
			end
			S_LAUNCH: state_d = S_DIV;
			S_DIV: begin
				if (rsp.done) begin
					priority if (d_past_root) begin
						state_d = S_FINAL;
					end else if (rsp.rem_zero) begin
						state_d = S_LAUNCH;
					end else if (d_at_lim) begin
						state_d = S_FINAL;
					end else begin
						state_d = S_LAUNCH;
					end
				end
			end
			S_FINAL: state_d = (rem_gt1 && !rem_le_lim) ? S_COF : S_RD;
			S_COF: begin
				if (out_acc) begin
					state_d = (cnt_q == '0) ? S_IDLE : S_RD;
				end
			end
			S_RD: state_d = S_OUT;
			S_OUT: begin
				if (out_acc) begin
					state_d = (idx_q == '0) ? S_IDLE : S_RD;
				end
			end
			S_SPECIAL: begin
				if (out_acc) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		m_tvalid  = 1'b0;
		m_tuser   = STAT_FACTOR;
		m_tlast   = 1'b0;
		factor    = '0;
		cofactor  = '0;
		mem_we    = 1'b0;
		mem_wdata = dvs_q;
		unique case (state_q)
			S_IDLE:   s_tready = 1'b1;
			S_LAUNCH: div_start = 1'b1;
			S_DIV: begin
				mem_we = rsp.done && !d_past_root && rsp.rem_zero && !cnt_q[CNT_W-1];
			end
			S_FINAL: begin
				mem_we    = left_store && !cnt_q[CNT_W-1];
				mem_wdata = LW'(rem_q);
			end
			S_COF: begin
				m_tvalid = 1'b1;
				m_tuser  = STAT_COF;
				m_tlast  = (cnt_q == '0);
				cofactor = cof_q;
			end
			S_RD: ;
			S_OUT: begin
				m_tvalid = 1'b1;
				m_tuser  = STAT_FACTOR;
				m_tlast  = (idx_q == '0);
				factor   = FACTOR_W'(rd_data);
			end
			S_SPECIAL: begin
				m_tvalid = 1'b1;
				m_tuser  = status_q;
				m_tlast  = 1'b1;
			end
			default: ;
		endcase
	end

	assign m_tdata = {(TDATA_W - NUM_W - FACTOR_W)'(0), cofactor, factor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cfg_q   <= LIMIT_RESET;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cnt_q <= '0;
					end
				end
				S_DIV: begin
					if (rsp.done && !d_past_root && rsp.rem_zero && !cnt_q[CNT_W-1]) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FINAL: begin
					cnt_q <= cnt_fin;
					idx_q <= IDX_W'(cnt_fin - 1'b1);
				end
				S_COF: begin
					if (out_acc) begin
						idx_q <= IDX_W'(cnt_q - 1'b1);
					end
				end
				S_OUT: begin
					if (out_acc) begin
						idx_q <= idx_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					rem_q    <= s_tdata;
					dvs_q    <= LW'(2);
					lim_q    <= lim_next;
					status_q <= (s_tdata == NUM_W'(0)) ? STAT_ZERO : STAT_ONE;
				end
			end
			S_DIV: begin
				if (rsp.done && !d_past_root) begin
					if (rsp.rem_zero) begin
						rem_q <= rsp.quot;
					end else if (!d_at_lim) begin
						dvs_q <= dvs_q + 1'b1;
					end
				end
			end
			S_FINAL: cof_q <= rem_q;
			default: ;
		endcase
	end

endmodule

FILE: rtl/tdpf_checker.sv
module tdpf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [tdpf_pkg::NUM_W-1:0]    s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tdpf_pkg::TDATA_W-1:0]  m_tdata,
	input logic [tdpf_pkg::STATUS_W-1:0] m_tuser,
	input logic                          m_tlast,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [tdpf_pkg::CFG_W-1:0]    cfg_data
);
	import tdpf_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again straight after a word");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("result offered while taking input");

	a_cof_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_COF |-> m_tdata[FACTOR_W +: NUM_W] == '0)
		else $error("cofactor set on non-cofactor word");

	a_special: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_ZERO || m_tuser == STAT_ONE)
			|-> m_tlast && m_tdata == '0)
		else $error("special status word malformed");

endmodule

bind trial_division_prime_factorizer_unit tdpf_checker u_tdpf_checker (.*);

FILE: tb/trial_division_prime_factorizer_unit_test.sv
`timescale 1ns / 1ps

module trial_division_prime_factorizer_unit_test;
	import tdpf_pkg::*;

	localparam int MAX_DIV        = 1048576;
	localparam int SETTLE_CYCLES  = 16;
	localparam int QUIET_LIMIT    = 300000;
	localparam int HOLD_CYCLES    = 20000;
	localparam int SMALL_PRIMES [25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
		53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

	typedef struct packed {
		logic [FACTOR_W-1:0] factor;
		status_t             status;
		logic [NUM_W-1:0]    cofactor;
		logic                last;
	} factor_word_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [NUM_W-1:0]    s_tdata   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic [STATUS_W-1:0] m_tuser;
	logic                m_tlast;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data  = '0;

	factor_word_t     pending_factor_words[$];
	logic [CFG_W-1:0] limit_copy = LIMIT_RESET;
	int               send_idle_pct  = 0;
	int               recv_stall_pct = 0;
	int               hold_left      = 0;
	int               quiet_cycles   = 0;
	int               error_count    = 0;
	int               numbers_sent   = 0;
	int               words_checked  = 0;
	int               limit_writes   = 0;

	trial_division_prime_factorizer_unit #(
		.MAX_DIVISOR(MAX_DIV)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic void queue_word(input logic [FACTOR_W-1:0] f, input status_t st,
		input logic [NUM_W-1:0] cof, input logic lst);
		factor_word_t w;
		w.factor   = f;
		w.status   = st;
		w.cofactor = cof;
		w.last     = lst;
		pending_factor_words.push_back(w);
	endfunction

	// expected factor words for one number under the current divisor limit
	function automatic void factorize_number(input logic [NUM_W-1:0] n);
		logic [63:0]         lim;
		logic [63:0]         rem;
		logic [63:0]         d;
		logic [63:0]         cof;
		logic [FACTOR_W-1:0] found[$];
		lim = limit_copy;
		if (lim < 2)
			lim = 2;
		else if (lim > MAX_DIV)
			lim = MAX_DIV;
		if (n == 0) begin
			queue_word('0, STAT_ZERO, '0, 1'b1);
			return;
		end
		if (n == 1) begin
			queue_word('0, STAT_ONE, '0, 1'b1);
			return;
		end
		rem = n;
		d   = 2;
		while (d <= lim && d * d <= rem) begin
			if (rem % d == 0) begin
				rem = rem / d;
				found.push_back(d[FACTOR_W-1:0]);
			end else
				d++;
		end
		cof = 0;
		if (rem > 1) begin
			if (rem <= lim)
				found.push_back(rem[FACTOR_W-1:0]);
			else
				cof = rem;
		end
		// an unfactored part exceeds every factor, so it leads
		if (cof != 0)
			queue_word('0, STAT_COF, cof, found.size() == 0);
		for (int i = found.size() - 1; i >= 0; i--)
			queue_word(found[i], STAT_FACTOR, '0, i == 0);
	endfunction

	always @(posedge clk) begin : word_monitor
		factor_word_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				limit_copy = cfg_data;
				limit_writes++;
			end
			if (s_tvalid && s_tready) begin
				factorize_number(s_tdata);
				numbers_sent++;
			end
			if (m_tvalid && m_tready) begin
				words_checked++;
				if (pending_factor_words.size() == 0)
					report_mismatch("word with none expected", m_tdata[63:0], '0);
				else begin
					want = pending_factor_words.pop_front();
					if (m_tdata[FACTOR_W-1:0] !== want.factor)
						report_mismatch("factor", m_tdata[FACTOR_W-1:0], want.factor);
					if (m_tuser !== want.status)
						report_mismatch("status", m_tuser, want.status);
					if (m_tdata[FACTOR_W +: NUM_W] !== want.cofactor)
						report_mismatch("cofactor", m_tdata[FACTOR_W +: NUM_W], want.cofactor);
					if (m_tdata[TDATA_W-1:FACTOR_W+NUM_W] !== '0)
						report_mismatch("tdata pad", m_tdata[TDATA_W-1:FACTOR_W+NUM_W], '0);
					if (m_tlast !== want.last)
						report_mismatch("last", m_tlast, want.last);
				end
			end
		end
	end

	// output side: random stalls, or a counted hold-off when asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_number(input logic [NUM_W-1:0] n);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, $urandom};
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= n;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		// let the monitor log a word taken at this very edge
		@(posedge clk);
		while (pending_factor_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [CFG_W-1:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_data  <= CFG_W'($urandom);
	endtask

	function automatic logic [NUM_W-1:0] smooth_number(input int max_factors);
		logic [NUM_W-1:0] n;
		logic [NUM_W-1:0] p;
		int               cnt;
		n   = 1;
		cnt = $urandom_range(max_factors, 1);
		repeat (cnt) begin
			p = ($urandom_range(3) == 0) ? 2 : SMALL_PRIMES[$urandom_range(24)];
			if (n > {NUM_W{1'b1}} / p)
				break;
			n = n * p;
		end
		return n;
	endfunction

	// with a wide limit, only numbers whose search ends early are cheap enough
	function automatic logic [NUM_W-1:0] pick_number(input bit wide_limit);
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return $urandom_range(1);
		if (r < 45)
			return smooth_number(63);
		if (r < 70 || wide_limit)
			return $urandom_range(16383, 2);
		return {$urandom, $urandom} >> $urandom_range(40);
	endfunction

	task automatic test_special_numbers();
		send_number(0);
		send_number(1);
		send_number(2);
		send_number(3);
		send_number(4);
		send_number(64'h8000_0000_0000_0000);
		send_number(8191);
		send_number(64'd223092870);
		send_number(64'd97 * 97 * 89);
	endtask

	task automatic test_limit_extremes();
		// limits below two act as two
		set_limit(0);
		send_number(64'hFFFF_FFFF_FFFF_FFFF);
		send_number(225);
		send_number(6);
		set_limit(1);
		send_number(12);
		send_number(64'hFFFF_FFFF_FFFF_FFFE);
		// above the divisor parameter, clamped
		set_limit({CFG_W{1'b1}});
		send_number(64'd12157665459056928801);
		send_number(64'hC000_0000_0000_0000);
		set_limit(1000);
		send_number(64'hFFFF_FFFF_FFFF_FFFF);
		send_number(64'd997 * 997);
		send_number(64'd2 * 997);
		send_number(64'd2 * 1009);
		set_limit(2);
		send_number(64'h8000_0000_0000_0000);
	endtask

	task automatic test_random_numbers(input int idle_pct, input int stall_pct);
		int wide;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		set_limit($urandom_range(120, 2));
		repeat (12) send_number(pick_number(1'b0));
		case ($urandom_range(3))
			0:       wide = MAX_DIV;
			1:       wide = {CFG_W{1'b1}};
			2:       wide = $urandom_range({CFG_W{1'b1}}, MAX_DIV + 1);
			default: wide = $urandom_range(MAX_DIV - 1, 1000);
		endcase
		set_limit(wide);
		repeat (9) send_number(pick_number(1'b1));
	endtask

	// hold-off outlasts the first number's search, so its words wait while input is offered
	task automatic test_output_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_limit(100);
		hold_left = HOLD_CYCLES;
		repeat (6) send_number(smooth_number(63));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_numbers();
		test_limit_extremes();
		test_random_numbers(0, 0);
		test_random_numbers(60, 0);
		test_random_numbers(0, 60);
		test_random_numbers(22, 22);
		test_output_backpressure();
		drain_results();
		repeat (50) @(posedge clk);
		$display("Factorized %0d numbers into %0d checked words over %0d limit settings,",
			numbers_sent, words_checked, limit_writes);
		$display("with idle sender, stalling receiver and a long output hold-off.");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: trial_division_prime_factorizer_unit.f
rtl/tdpf_pkg.sv
rtl/tdpf_div.sv
rtl/tdpf_store.sv
rtl/trial_division_prime_factorizer_unit.sv
rtl/tdpf_checker.sv
tb/trial_division_prime_factorizer_unit_test.sv
